### rtl/ffud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffud_pkg;

    localparam int MAX_NAME_DEF = 32;
    localparam int KEY_LEN      = 5;

    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_KEY_N = 8'h6E;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_CAPTURE = 2'd1,
        PH_CLOSED  = 2'd2,
        PH_NOKEY   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_CHAR = 2'd2
    } t_esc;

    typedef enum logic [1:0] {
        S_RUN     = 2'd0,
        S_CLOSE2  = 2'd1,
        S_EMIT_RD = 2'd2,
        S_EMIT_LD = 2'd3
    } t_state;

    typedef struct packed {
        logic take;
        logic close2;
        logic rd;
        logic load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic need_close2;
        logic last;
        logic out_free;
    } t_status;

    function automatic logic [7:0] key_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h6E;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h63;
            3'd3:    c = 8'h6B;
            3'd4:    c = 8'h3D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return (c == C_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end else begin
            v = 5'd0;
        end
        return v;
    endfunction

    function automatic logic [7:0] parse_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] r;
        ha = hex_val(a);
        hb = hex_val(b);
        if (ha[4]) begin
            r = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
        end else if (!hb[4]) begin
            r = 8'd0;
        end else if (is_white(a) || a == C_PLUS) begin
            r = {4'd0, hb[3:0]};
        end else if (a == C_MINUS) begin
            r = 8'd0 - {4'd0, hb[3:0]};
        end else begin
            r = 8'd0;
        end
        return r;
    endfunction

    function automatic logic [7:0] plain_char(input logic [7:0] c);
        return (c == C_PLUS) ? C_SPACE : c;
    endfunction

endpackage

`default_nettype wire

### rtl/ffud_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ffud_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ffud_pkg::MAX_NAME_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic                                     i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/ffud_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ffud_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_body_valid,
    input  wire logic              i_end_of_body,
    input  wire ffud_pkg::t_status i_status,
    output logic                   o_body_stall,
    output ffud_pkg::t_cmd         o_cmd
);

    ffud_pkg::t_state r_state;
    ffud_pkg::t_state n_state;
    logic             r_eob;
    logic             n_eob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffud_pkg::S_RUN;
            r_eob   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eob   <= n_eob;
        end
    end

    always_comb begin
        n_state = r_state;
        n_eob   = r_eob;
        case (r_state)
            ffud_pkg::S_RUN: begin
                if (i_body_valid) begin
                    n_eob = i_end_of_body;
                    if (i_status.need_close2) begin
                        n_state = ffud_pkg::S_CLOSE2;
                    end else if (i_end_of_body) begin
                        n_state = ffud_pkg::S_EMIT_RD;
                    end
                end
            end
            ffud_pkg::S_CLOSE2: begin
                n_state = r_eob ? ffud_pkg::S_EMIT_RD : ffud_pkg::S_RUN;
            end
            ffud_pkg::S_EMIT_RD: begin
                n_state = ffud_pkg::S_EMIT_LD;
            end
            ffud_pkg::S_EMIT_LD: begin
                if (i_status.out_free) begin
                    n_state = i_status.last ? ffud_pkg::S_RUN : ffud_pkg::S_EMIT_RD;
                end
            end
            default: n_state = ffud_pkg::S_RUN;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_body_stall = 1'b1;
        case (r_state)
            ffud_pkg::S_RUN: begin
                o_body_stall = 1'b0;
                o_cmd.take   = i_body_valid;
            end
            ffud_pkg::S_CLOSE2: begin
                o_cmd.close2 = 1'b1;
            end
            ffud_pkg::S_EMIT_RD: begin
                o_cmd.rd = 1'b1;
            end
            ffud_pkg::S_EMIT_LD: begin
                o_cmd.load  = i_status.out_free;
                o_cmd.clear = i_status.out_free && i_status.last;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### rtl/ffud_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ffud_datapath #(
    parameter int MAX_NAME = ffud_pkg::MAX_NAME_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ffud_pkg::t_cmd i_cmd,
    output ffud_pkg::t_status   o_status,
    input  wire logic [7:0]     i_body_byte,
    input  wire logic           i_end_of_body,
    input  wire logic           i_name_stall,
    output logic                o_name_valid,
    output logic [7:0]          o_name_byte,
    output logic                o_name_ok,
    output logic                o_last_of_name
);

    localparam int CW = $clog2(MAX_NAME + 1);
    localparam int AW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;

    logic [2:0]       r_key_pos, n_key_pos;
    ffud_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]    r_raw_cnt, n_raw_cnt;
    ffud_pkg::t_esc   r_esc_step, n_esc_step;
    logic [7:0]       r_esc_char, n_esc_char;
    logic [CW-1:0]    r_stored, n_stored;
    logic [CW-1:0]    r_trimmed, n_trimmed;
    logic [CW-1:0]    r_rd_cnt, n_rd_cnt;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_ok, n_out_ok;
    logic             r_out_last, n_out_last;

    logic             put_valid;
    logic [7:0]       put_byte;
    logic             wr_en;
    logic             term;
    logic             closing;
    logic             need2;
    ffud_pkg::t_esc   step_t;
    logic [7:0]       rd_data;
    logic             last_byte;

    ffud_ram #(
        .WIDTH (8),
        .DEPTH (MAX_NAME)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_stored[AW-1:0]),
        .i_wr_data (put_byte),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_rd_cnt[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign last_byte = (r_trimmed == '0) || (CW'(r_rd_cnt + 1'b1) == r_trimmed);

    always_comb begin
        n_key_pos   = r_key_pos;
        n_phase     = r_phase;
        n_raw_cnt   = r_raw_cnt;
        n_esc_step  = r_esc_step;
        n_esc_char  = r_esc_char;
        n_stored    = r_stored;
        n_trimmed   = r_trimmed;
        n_rd_cnt    = r_rd_cnt;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_ok    = r_out_ok;
        n_out_last  = r_out_last;
        put_valid   = 1'b0;
        put_byte    = 8'd0;
        wr_en       = 1'b0;
        term        = 1'b0;
        closing     = 1'b0;
        need2       = 1'b0;
        step_t      = r_esc_step;

        if (i_cmd.take) begin
            case (r_phase)
                ffud_pkg::PH_SEARCH: begin
                    if (i_body_byte == 8'd0) begin
                        n_phase = ffud_pkg::PH_NOKEY;
                    end else if (i_body_byte == ffud_pkg::key_char(r_key_pos)) begin
                        if (r_key_pos == 3'(ffud_pkg::KEY_LEN - 1)) begin
                            n_key_pos = 3'd0;
                            n_phase   = ffud_pkg::PH_CAPTURE;
                        end else begin
                            n_key_pos = r_key_pos + 3'd1;
                        end
                    end else begin
                        n_key_pos = (i_body_byte == ffud_pkg::C_KEY_N) ? 3'd1 : 3'd0;
                    end
                end
                ffud_pkg::PH_CAPTURE: begin
                    term = (i_body_byte == 8'd0) || (i_body_byte == ffud_pkg::C_AMP);
                    if (!term) begin
                        n_raw_cnt = CW'(r_raw_cnt + 1'b1);
                        case (r_esc_step)
                            ffud_pkg::ESC_PCT: begin
                                step_t     = ffud_pkg::ESC_CHAR;
                                n_esc_char = i_body_byte;
                            end
                            ffud_pkg::ESC_CHAR: begin
                                step_t    = ffud_pkg::ESC_NONE;
                                put_valid = 1'b1;
                                put_byte  = ffud_pkg::parse_pair(r_esc_char, i_body_byte);
                            end
                            default: begin
                                if (i_body_byte == ffud_pkg::C_PCT) begin
                                    step_t = ffud_pkg::ESC_PCT;
                                end else begin
                                    put_valid = 1'b1;
                                    put_byte  = ffud_pkg::plain_char(i_body_byte);
                                end
                            end
                        endcase
                    end
                    closing = term || i_end_of_body
                              || (r_raw_cnt == CW'(MAX_NAME - 1));
                    if (closing) begin
                        // pending escape is kept literally
                        if (step_t != ffud_pkg::ESC_NONE) begin
                            put_valid = 1'b1;
                            put_byte  = ffud_pkg::C_PCT;
                        end
                        need2 = (step_t == ffud_pkg::ESC_CHAR);
                        if (need2) begin
                            n_esc_step = ffud_pkg::ESC_CHAR;
                        end else begin
                            n_esc_step = ffud_pkg::ESC_NONE;
                            n_phase    = ffud_pkg::PH_CLOSED;
                        end
                    end else begin
                        n_esc_step = step_t;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.close2) begin
            put_valid  = 1'b1;
            put_byte   = ffud_pkg::plain_char(r_esc_char);
            n_phase    = ffud_pkg::PH_CLOSED;
            n_esc_step = ffud_pkg::ESC_NONE;
        end

        if (put_valid) begin
            if (put_byte == 8'd0) begin
                n_phase = ffud_pkg::PH_CLOSED;
            end else if (!((r_stored == '0) && ffud_pkg::is_white(put_byte))
                         && (r_stored < CW'(MAX_NAME))) begin
                wr_en    = 1'b1;
                n_stored = CW'(r_stored + 1'b1);
                if (!ffud_pkg::is_white(put_byte)) begin
                    n_trimmed = CW'(r_stored + 1'b1);
                end
            end
        end

        if (i_cmd.load) begin
            n_out_valid = 1'b1;
            if (r_trimmed == '0) begin
                n_out_byte = 8'd0;
                n_out_ok   = 1'b0;
                n_out_last = 1'b1;
            end else begin
                n_out_byte = rd_data;
                n_out_ok   = 1'b1;
                n_out_last = last_byte;
            end
            n_rd_cnt = CW'(r_rd_cnt + 1'b1);
        end else if (!i_name_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.clear) begin
            n_key_pos  = 3'd0;
            n_phase    = ffud_pkg::PH_SEARCH;
            n_raw_cnt  = '0;
            n_esc_step = ffud_pkg::ESC_NONE;
            n_esc_char = 8'd0;
            n_stored   = '0;
            n_trimmed  = '0;
            n_rd_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos   <= 3'd0;
            r_phase     <= ffud_pkg::PH_SEARCH;
            r_raw_cnt   <= '0;
            r_esc_step  <= ffud_pkg::ESC_NONE;
            r_esc_char  <= 8'd0;
            r_stored    <= '0;
            r_trimmed   <= '0;
            r_rd_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_key_pos   <= n_key_pos;
            r_phase     <= n_phase;
            r_raw_cnt   <= n_raw_cnt;
            r_esc_step  <= n_esc_step;
            r_esc_char  <= n_esc_char;
            r_stored    <= n_stored;
            r_trimmed   <= n_trimmed;
            r_rd_cnt    <= n_rd_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_ok   <= n_out_ok;
        r_out_last <= n_out_last;
    end

    assign o_status.need_close2 = need2;
    assign o_status.last        = last_byte;
    assign o_status.out_free    = !r_out_valid || !i_name_stall;

    assign o_name_valid   = r_out_valid;
    assign o_name_byte    = r_out_byte;
    assign o_name_ok      = r_out_ok;
    assign o_last_of_name = r_out_last;

    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stored <= CW'(MAX_NAME)) && (r_trimmed <= r_stored))
        else $error("stored length out of bounds");

    a_close2_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.close2 |-> (r_phase == ffud_pkg::PH_CAPTURE)
                         && (r_esc_step == ffud_pkg::ESC_CHAR))
        else $error("second close write without pending escape");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && (r_trimmed != '0)) |-> (r_rd_cnt < r_trimmed))
        else $error("name read past trimmed length");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_valid || !i_name_stall))
        else $error("output overwritten before transfer");

endmodule

`default_nettype wire

### rtl/form_field_url_decoder.sv
// form field url decoder
// input channel: i_body_valid / o_body_stall with i_body_byte and i_end_of_body,
// one body byte per transfer; a transfer completes when valid is high and stall low
// output channel: o_name_valid / i_name_stall with o_name_byte, o_name_ok and
// o_last_of_name, one decoded name byte per transfer
// the block scans for the first "nick=", captures and percent-decodes the value,
// trims white space, and after the final body byte sends the name bytes, or one
// failure transfer (byte 0, ok 0, last 1) when the key is missing or the name empty
// throughput: one body byte per cycle while o_body_stall is low; a value closed
// while a two-character escape is still pending passes through S_CLOSE2 for the
// second store write
// flush: each name byte takes a registered name memory read (S_EMIT_RD), then an
// output register load (S_EMIT_LD) that waits while the receiver stalls
// the input stalls during the flush; it is taken again once the last result
// sits in the output register, which holds while the receiver stalls
// reset clears all control state; no memory clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module form_field_url_decoder #(
    parameter int MAX_NAME = ffud_pkg::MAX_NAME_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_body_valid,
    output logic            o_body_stall,
    input  wire logic [7:0] i_body_byte,
    input  wire logic       i_end_of_body,
    output logic            o_name_valid,
    input  wire logic       i_name_stall,
    output logic [7:0]      o_name_byte,
    output logic            o_name_ok,
    output logic            o_last_of_name
);

    ffud_pkg::t_cmd    cmd;
    ffud_pkg::t_status status;

    ffud_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_body_valid  (i_body_valid),
        .i_end_of_body (i_end_of_body),
        .i_status      (status),
        .o_body_stall  (o_body_stall),
        .o_cmd         (cmd)
    );

    ffud_datapath #(
        .MAX_NAME (MAX_NAME)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_body_byte    (i_body_byte),
        .i_end_of_body  (i_end_of_body),
        .i_name_stall   (i_name_stall),
        .o_name_valid   (o_name_valid),
        .o_name_byte    (o_name_byte),
        .o_name_ok      (o_name_ok),
        .o_last_of_name (o_last_of_name)
    );

endmodule

`default_nettype wire
